@@ rtl/abrb_pkg.sv @@
// Shared types and constants for the audio block ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package abrb_pkg;

    // Default sizing
    localparam int SLOTS_DEF        = 8;
    localparam int BLOCK_FRAMES_DEF = 32;

    // Capacity register value after reset
    localparam logic [3:0] CAP_RESET = 4'd8;

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 168;

    // Request kinds carried in s_tuser
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_PEEK    = 2'd1;
    localparam logic [1:0] KIND_CONSUME = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_PEEK
    } state_t;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_COMMIT,
        RES_EMPTY,
        RES_DONE,
        RES_HEAD_ZERO,
        RES_FRAME
    } res_sel_t;

    typedef struct packed {
        logic     push;
        logic     consume;
        logic     peek_start;
        logic     peek_emit;
        logic     load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic head_zero;
        logic peek_last;
    } stat_t;

    typedef struct packed {
        logic [31:0] pushes;
        logic [31:0] drop_frames;
        logic [31:0] drop_blocks;
        logic [3:0]  peak;
        logic [3:0]  used;
        logic [5:0]  frames;
        logic [19:0] rate;
        logic [15:0] right;
        logic [15:0] left;
        logic        last;
        logic        empty;
        logic        ok;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/abrb_ctrl.sv @@
// Controller state machine: request acceptance, peek sequencing, output valid.
`timescale 1ns / 1ps
`default_nettype none

module abrb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [1:0]     s_tuser,
    input  wire logic           s_tlast,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire abrb_pkg::stat_t stat,
    output abrb_pkg::cmd_t      cmd
);
    import abrb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // Decode requests and step through a peek run
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    case (s_tuser)
                        KIND_PUSH:
                        begin
                            cmd.push = 1'b1;
                            if (s_tlast)
                            begin
                                cmd.load    = 1'b1;
                                cmd.res_sel = RES_COMMIT;
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (stat.ring_empty)
                            begin
                                cmd.load    = 1'b1;
                                cmd.res_sel = RES_EMPTY;
                            end
                            else if (stat.head_zero)
                            begin
                                cmd.load    = 1'b1;
                                cmd.res_sel = RES_HEAD_ZERO;
                            end
                            else
                            begin
                                cmd.peek_start = 1'b1;
                                state_next     = ST_PEEK;
                            end
                        end
                        KIND_CONSUME:
                        begin
                            cmd.consume = 1'b1;
                            cmd.load    = 1'b1;
                            cmd.res_sel = stat.ring_empty ? RES_EMPTY : RES_DONE;
                        end
                        default:
                        begin
                            // drop unknown kinds silently
                        end
                    endcase
                end
            end
            ST_PEEK:
            begin
                if (out_free)
                begin
                    cmd.peek_emit = 1'b1;
                    cmd.load      = 1'b1;
                    cmd.res_sel   = RES_FRAME;
                    if (stat.peek_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register is full after a load, empty once taken
    always_comb
    begin
        out_valid_next = cmd.load || (out_valid_reg && !m_tready);
    end

endmodule

`default_nettype wire

@@ rtl/abrb_dpath.sv @@
// Datapath: frame memory, slot tables, ring pointers, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module abrb_dpath #(
    parameter int SLOTS        = abrb_pkg::SLOTS_DEF,
    parameter int BLOCK_FRAMES = abrb_pkg::BLOCK_FRAMES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [3:0]       cfg_data,
    input  wire abrb_pkg::cmd_t   cmd,
    input  wire logic [15:0]      in_left,
    input  wire logic [15:0]      in_right,
    input  wire logic [19:0]      in_rate,
    input  wire logic             in_eob,
    output abrb_pkg::stat_t       stat,
    output abrb_pkg::result_t     res
);
    import abrb_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(BLOCK_FRAMES + 1);
    localparam int DEPTH = SLOTS * BLOCK_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control and counter state
    logic [3:0]    cap_reg;
    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [3:0]    occ_reg, occ_next;
    logic [3:0]    hm_reg, hm_next;
    logic [31:0]   dbt_reg, dbt_next;
    logic [31:0]   dft_reg, dft_next;
    logic [31:0]   pbt_reg, pbt_next;
    logic          in_block_reg, in_block_next;
    logic          dropping_reg, dropping_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] pk_idx_reg, pk_idx_next;

    // Storage
    logic [31:0]   frame_store [DEPTH];
    logic [19:0]   slot_rate   [SLOTS];
    logic [FW-1:0] slot_frames [SLOTS];
    logic [31:0]   rd_data_reg;
    result_t       res_reg;

    // Working signals
    logic [3:0]    cap_now;
    logic [SW-1:0] ws_wrap, rs_wrap;
    logic          first_item, drop_now;
    logic [FW-1:0] fill_base;
    logic [AW-1:0] wbase, rbase;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          slot_we;
    logic          rd_en;
    logic [FW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] head_n;
    logic [FW-1:0] pk_idx_inc;
    logic [3:0]    occ_inc;

    // Clamp the capacity register to 1..SLOTS
    always_comb
    begin
        if (cap_reg == 4'd0)
        begin
            cap_now = 4'd1;
        end
        else if (32'(cap_reg) > SLOTS)
        begin
            cap_now = 4'(SLOTS);
        end
        else
        begin
            cap_now = cap_reg;
        end
    end

    // Advance slot pointers, wrapping at the current capacity
    assign ws_wrap = (8'(ws_reg) + 8'd1 >= 8'(cap_now)) ? '0 : SW'(ws_reg + 1'b1);
    assign rs_wrap = (8'(rs_reg) + 8'd1 >= 8'(cap_now)) ? '0 : SW'(rs_reg + 1'b1);

    assign wbase      = AW'(ws_reg) * AW'(BLOCK_FRAMES);
    assign rbase      = AW'(rs_reg) * AW'(BLOCK_FRAMES);
    assign head_n     = slot_frames[rs_reg];
    assign pk_idx_inc = pk_idx_reg + 1'b1;
    assign occ_inc    = (32'(occ_reg) < SLOTS) ? occ_reg + 4'd1 : occ_reg;

    assign first_item = !in_block_reg;
    assign drop_now   = first_item ? (occ_reg >= cap_now) : dropping_reg;
    assign fill_base  = first_item ? '0 : fill_reg;

    assign stat.ring_empty = (occ_reg == 4'd0);
    assign stat.head_zero  = (head_n == '0);
    assign stat.peek_last  = (pk_idx_inc == head_n);

    // Next state of pointers, counters and push tracking
    always_comb
    begin
        ws_next       = ws_reg;
        rs_next       = rs_reg;
        occ_next      = occ_reg;
        hm_next       = hm_reg;
        dbt_next      = dbt_reg;
        dft_next      = dft_reg;
        pbt_next      = pbt_reg;
        in_block_next = in_block_reg;
        dropping_next = dropping_reg;
        fill_next     = fill_reg;
        mem_we        = 1'b0;
        mem_waddr     = wbase + AW'(fill_base);
        slot_we       = 1'b0;
        if (cmd.push)
        begin
            fill_next = fill_base;
            if (drop_now)
            begin
                dft_next = dft_reg + 32'd1;
            end
            else if (32'(fill_base) < BLOCK_FRAMES)
            begin
                mem_we    = 1'b1;
                fill_next = fill_base + 1'b1;
            end
            if (in_eob)
            begin
                if (drop_now)
                begin
                    dbt_next = dbt_reg + 32'd1;
                end
                else
                begin
                    slot_we  = 1'b1;
                    ws_next  = ws_wrap;
                    occ_next = occ_inc;
                    if (occ_inc > hm_reg)
                    begin
                        hm_next = occ_inc;
                    end
                    pbt_next = pbt_reg + 32'd1;
                end
                in_block_next = 1'b0;
                dropping_next = 1'b0;
            end
            else
            begin
                in_block_next = 1'b1;
                dropping_next = drop_now;
            end
        end
        if (cmd.consume && (occ_reg != 4'd0))
        begin
            rs_next  = rs_wrap;
            occ_next = occ_reg - 4'd1;
        end
    end

    // Peek read address and frame index
    assign rd_en   = cmd.peek_start || (cmd.peek_emit && !stat.peek_last);
    assign rd_idx  = cmd.peek_start ? '0 : pk_idx_inc;
    assign rd_addr = rbase + AW'(rd_idx);

    always_comb
    begin
        pk_idx_next = pk_idx_reg;
        if (cmd.peek_start)
        begin
            pk_idx_next = '0;
        end
        else if (cmd.peek_emit && !stat.peek_last)
        begin
            pk_idx_next = pk_idx_inc;
        end
    end

    // Hold control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            ws_reg       <= '0;
            rs_reg       <= '0;
            occ_reg      <= '0;
            hm_reg       <= '0;
            dbt_reg      <= '0;
            dft_reg      <= '0;
            pbt_reg      <= '0;
            in_block_reg <= 1'b0;
            dropping_reg <= 1'b0;
            fill_reg     <= '0;
            pk_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            ws_reg       <= ws_next;
            rs_reg       <= rs_next;
            occ_reg      <= occ_next;
            hm_reg       <= hm_next;
            dbt_reg      <= dbt_next;
            dft_reg      <= dft_next;
            pbt_reg      <= pbt_next;
            in_block_reg <= in_block_next;
            dropping_reg <= dropping_next;
            fill_reg     <= fill_next;
            pk_idx_reg   <= pk_idx_next;
        end
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= {in_left, in_right};
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_store[rd_addr];
        end
    end

    // Slot tables, written when a block commits
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_rate[ws_reg]   <= in_rate;
            slot_frames[ws_reg] <= fill_next;
        end
    end

    // Load the output register with the selected result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg.pushes      <= pbt_next;
            res_reg.drop_frames <= dft_next;
            res_reg.drop_blocks <= dbt_next;
            res_reg.peak        <= hm_next;
            res_reg.used        <= occ_next;
            res_reg.frames      <= '0;
            res_reg.rate        <= '0;
            res_reg.right       <= '0;
            res_reg.left        <= '0;
            res_reg.last        <= 1'b1;
            res_reg.empty       <= 1'b0;
            res_reg.ok          <= 1'b0;
            case (cmd.res_sel)
                RES_COMMIT:
                begin
                    res_reg.ok <= !drop_now;
                end
                RES_EMPTY:
                begin
                    res_reg.empty <= 1'b1;
                end
                RES_HEAD_ZERO:
                begin
                    res_reg.rate <= slot_rate[rs_reg];
                end
                RES_FRAME:
                begin
                    res_reg.left   <= rd_data_reg[31:16];
                    res_reg.right  <= rd_data_reg[15:0];
                    res_reg.rate   <= slot_rate[rs_reg];
                    res_reg.frames <= 6'(head_n);
                    res_reg.last   <= stat.peek_last;
                end
                default:
                begin
                    // plain completion, nothing more to fill
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ rtl/audio_block_ring_buffer.sv @@
// Top level of the audio block ring buffer: stream ports, controller and datapath.
//
// Requests enter on the s_ stream; s_tuser carries the kind (push frame, peek, consume)
// and s_tlast marks the final frame of a pushed block. Results leave on the m_ stream,
// m_tlast marking the final result of a request. A capacity write on cfg_ sets how
// many slots of the ring are in use; it is taken at any cycle and is meant for idle.
// Push frames are taken one per cycle while the output register is free; a non-final
// frame gives no result, the final one a single commit result in the next cycle.
// Peek on a non-empty ring streams the head block via the read data register and the
// output register, one frame per cycle while it is free, paced by the single read
// port of the frame memory. Empty-ring peek and consume answer in the next cycle.
// A new request is taken in the idle state whenever the output register is free or
// being emptied in the same cycle; while m_tready is low the result is held and
// s_tready drops. A peek run blocks new requests until its last frame is loaded.
// Reset clears pointers, occupancy, counters and the output valid flag; the capacity
// returns to eight slots. Stored frames stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module audio_block_ring_buffer #(
    parameter int SLOTS        = abrb_pkg::SLOTS_DEF,
    parameter int BLOCK_FRAMES = abrb_pkg::BLOCK_FRAMES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // cfg_data: slot_capacity[3:0]
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [3:0]                     cfg_data,
    // s_tdata: left_sample[15:0], right_sample[31:16], rate_hz[51:32], zero pad
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [abrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    // s_tuser: kind[1:0]
    input  wire logic [1:0]                     s_tuser,
    // m_tdata: out_left[15:0], out_right[31:16], block_rate[51:32],
    //          block_frame_count[57:52], used_blocks[61:58], peak_used[65:62],
    //          drop_block_count[97:66], drop_frame_count[129:98],
    //          push_count[161:130], zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [abrb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // m_tuser: empty_res[0], push_ok[1]
    output logic [1:0]                          m_tuser
);
    import abrb_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    result_t res;

    assign cfg_ready = 1'b1;

    abrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abrb_dpath #(
        .SLOTS        (SLOTS),
        .BLOCK_FRAMES (BLOCK_FRAMES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .in_left  (s_tdata[15:0]),
        .in_right (s_tdata[31:16]),
        .in_rate  (s_tdata[51:32]),
        .in_eob   (s_tlast),
        .stat     (stat),
        .res      (res)
    );

    // Pack the result onto the master stream
    assign m_tdata = {6'd0, res.pushes, res.drop_frames, res.drop_blocks, res.peak,
                      res.used, res.frames, res.rate, res.right, res.left};
    assign m_tlast = res.last;
    assign m_tuser = {res.ok, res.empty};

endmodule

`default_nettype wire

@@ rtl/abrb_checker.sv @@
// Port-level assertions for the audio block ring buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module abrb_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [abrb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast,
    input wire logic [1:0]                     m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // Occupancy never exceeds the high mark
    a_used_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[61:58] <= m_tdata[65:62])
        else $error("used_blocks above peak_used");

    // An empty answer means nothing is stored
    a_empty_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[61:58] == 4'd0 && m_tlast)
        else $error("empty result with blocks in use");

    // Push commit and empty flags never together
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("push_ok and empty_res both set");

endmodule

bind audio_block_ring_buffer abrb_checker u_abrb_checker (.*);

`default_nettype wire
